>>> sv/lcp_pkg.sv
// Package for the line command parser: reply and line-kind codes, match
// automaton states, the result record and the fixed keyword tables.
// No dependencies; every module of the parser imports it.
package lcp_pkg;

    // Default line length limit in bytes (CR excluded).
    localparam int LCP_LINE_LIMIT = 64;

    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_COLON = 8'h3A;

    typedef enum logic [2:0] {
        REPLY_NONE    = 3'd0,
        REPLY_PONG    = 3'd1,
        REPLY_OK      = 3'd2,
        REPLY_UNKNOWN = 3'd3,
        REPLY_ERROR   = 3'd4
    } reply_t;

    typedef enum logic [3:0] {
        KIND_PING         = 4'd0,
        KIND_PONG         = 4'd1,
        KIND_LED_ON       = 4'd2,
        KIND_LED_OFF      = 4'd3,
        KIND_UNKNOWN_CMD  = 4'd4,
        KIND_STATUS       = 4'd5,
        KIND_NO_COLON     = 4'd6,
        KIND_UNKNOWN_TYPE = 4'd7,
        KIND_BAD_CHARSET  = 4'd8,
        KIND_OVERFLOW     = 4'd9
    } kind_t;

    typedef enum logic [3:0] {
        M_START      = 4'd0,
        M_P          = 4'd1,
        M_PING       = 4'd2,
        M_PONG       = 4'd3,
        M_CMD        = 4'd4,
        M_STATUS     = 4'd5,
        M_TYPE_OTHER = 4'd6,
        M_CMD_PAY    = 4'd7,
        M_CMD_ON     = 4'd8,
        M_CMD_OF     = 4'd9,
        M_CMD_OFF    = 4'd10,
        M_CMD_UNK    = 4'd11,
        M_STATUS_PAY = 4'd12,
        M_OTHER_PAY  = 4'd13
    } match_t;

    // One result; packed so that reply sits in the lowest bits.
    typedef struct packed {
        logic   led_on;
        kind_t  line_kind;
        reply_t reply;
    } result_t;

    // Keyword characters by position. Out-of-range positions never match
    // because the caller checks the position against the word length first.
    function automatic logic [7:0] ping_char(input logic [2:0] pos);
        case (pos)
            3'd0:    ping_char = "P";
            3'd1:    ping_char = "I";
            3'd2:    ping_char = "N";
            default: ping_char = "G";
        endcase
    endfunction

    function automatic logic [7:0] pong_char(input logic [2:0] pos);
        case (pos)
            3'd0:    pong_char = "P";
            3'd1:    pong_char = "O";
            3'd2:    pong_char = "N";
            default: pong_char = "G";
        endcase
    endfunction

    function automatic logic [7:0] cmd_char(input logic [2:0] pos);
        case (pos)
            3'd0:    cmd_char = "C";
            3'd1:    cmd_char = "M";
            default: cmd_char = "D";
        endcase
    endfunction

    function automatic logic [7:0] status_char(input logic [2:0] pos);
        case (pos)
            3'd0:    status_char = "S";
            3'd1:    status_char = "T";
            3'd2:    status_char = "A";
            3'd3:    status_char = "T";
            3'd4:    status_char = "U";
            default: status_char = "S";
        endcase
    endfunction

    function automatic logic [7:0] led_char(input logic [2:0] pos);
        case (pos)
            3'd0:    led_char = "L";
            3'd1:    led_char = "E";
            3'd2:    led_char = "D";
            3'd3:    led_char = "_";
            default: led_char = "O";
        endcase
    endfunction

endpackage

>>> sv/line_command_parser.sv
// Top level of the line command parser: byte input register, parse core and
// result register. Depends on lcp_pkg, lcp_parse_core and lcp_out_reg.
//
//   Channel  Dir  tdata fields (low bit up)            Request
//   s_       in   rx_byte[7:0]                         one received byte
//   m_       out  reply[2:0] line_kind[6:3] led_on[7]  one line result
//
// An accepted byte is held in the input register, and its line result, if any,
// in the result register. One byte is accepted per cycle unless the output stalls.
// A stalled result register holds the parse step, and the input register
// then holds its byte; s_tready drops only when both are full.
// Reset clears the line state, the LED level and both valid flags.
module line_command_parser #(
    parameter int LINE_LIMIT = lcp_pkg::LCP_LINE_LIMIT
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,    // rx_byte[7:0]
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata     // reply[2:0], line_kind[6:3], led_on[7]
);
    import lcp_pkg::*;

    logic       in_valid_reg, in_valid_next;
    logic [7:0] in_byte_reg;
    logic       can_load;
    logic       step_en;
    logic       res_valid;
    result_t    res_data;

    // The held byte is parsed once the result register can take its result.
    assign step_en       = in_valid_reg && can_load;
    assign s_tready      = !in_valid_reg || can_load;
    assign in_valid_next = s_tready ? s_tvalid : in_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata;
        end
    end

    lcp_parse_core #(
        .LINE_LIMIT (LINE_LIMIT)
    ) u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step_en   (step_en),
        .step_byte (in_byte_reg),
        .res_valid (res_valid),
        .res_data  (res_data)
    );

    lcp_out_reg u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .res_valid (res_valid),
        .res_data  (res_data),
        .can_load  (can_load),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

>>> sv/lcp_parse_core.sv
// Parse core of the line command parser: per-line matching state, the LED
// level and the single-byte step logic that classifies a line as it arrives.
// Depends on lcp_pkg.
module lcp_parse_core #(
    parameter int LINE_LIMIT = lcp_pkg::LCP_LINE_LIMIT
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             step_en,
    input  logic [7:0]       step_byte,
    output logic             res_valid,
    output lcp_pkg::result_t res_data
);
    import lcp_pkg::*;

    localparam int CNT_W = $clog2(LINE_LIMIT + 1);
    localparam logic [CNT_W-1:0] LIMIT_C = CNT_W'(LINE_LIMIT);

    logic [CNT_W-1:0] char_count_reg, char_count_next;
    logic             seen_reg, seen_next;
    logic             gap_reg, gap_next;
    logic             bad_reg, bad_next;
    logic             colon_reg, colon_next;
    match_t           mstate_reg, mstate_next;
    logic [2:0]       mpos_reg, mpos_next;
    logic             led_reg, led_next;

    logic             is_blank;
    logic             is_allowed;
    logic             bad_now;
    reply_t           reply_sel;
    kind_t            kind_sel;

    // Character classes of the incoming byte.
    assign is_blank   = (step_byte == 8'h09) || (step_byte == 8'h0B) ||
                        (step_byte == 8'h0C) || (step_byte == 8'h20);
    assign is_allowed = ((step_byte >= "A") && (step_byte <= "Z")) ||
                        ((step_byte >= "0") && (step_byte <= "9")) ||
                        (step_byte == "_") || (step_byte == CHAR_COLON);

    // Next state and result for one byte.
    always_comb begin
        char_count_next = char_count_reg;
        seen_next       = seen_reg;
        gap_next        = gap_reg;
        bad_next        = bad_reg;
        colon_next      = colon_reg;
        mstate_next     = mstate_reg;
        mpos_next       = mpos_reg;
        led_next        = led_reg;
        res_valid       = 1'b0;
        reply_sel       = REPLY_NONE;
        kind_sel        = KIND_PING;
        bad_now         = bad_reg | gap_reg | ~is_allowed;

        if (step_en && step_byte != CHAR_CR) begin
            if (step_byte == CHAR_LF || char_count_reg >= LIMIT_C) begin
                // End of line or overflow: classify, then clear the line.
                if (step_byte != CHAR_LF) begin
                    res_valid = 1'b1;
                    reply_sel = REPLY_ERROR;
                    kind_sel  = KIND_OVERFLOW;
                end else if (seen_reg) begin
                    res_valid = 1'b1;
                    if (bad_reg) begin
                        reply_sel = REPLY_ERROR;
                        kind_sel  = KIND_BAD_CHARSET;
                    end else if (mstate_reg == M_PING && mpos_reg == 3'd4) begin
                        reply_sel = REPLY_PONG;
                        kind_sel  = KIND_PING;
                    end else if (mstate_reg == M_PONG && mpos_reg == 3'd4) begin
                        reply_sel = REPLY_NONE;
                        kind_sel  = KIND_PONG;
                    end else if (!colon_reg) begin
                        reply_sel = REPLY_ERROR;
                        kind_sel  = KIND_NO_COLON;
                    end else if (mstate_reg == M_CMD_ON) begin
                        led_next  = 1'b1;
                        reply_sel = REPLY_OK;
                        kind_sel  = KIND_LED_ON;
                    end else if (mstate_reg == M_CMD_OFF) begin
                        led_next  = 1'b0;
                        reply_sel = REPLY_OK;
                        kind_sel  = KIND_LED_OFF;
                    end else if (mstate_reg == M_STATUS_PAY) begin
                        reply_sel = REPLY_NONE;
                        kind_sel  = KIND_STATUS;
                    end else if (mstate_reg == M_OTHER_PAY) begin
                        reply_sel = REPLY_ERROR;
                        kind_sel  = KIND_UNKNOWN_TYPE;
                    end else begin
                        reply_sel = REPLY_UNKNOWN;
                        kind_sel  = KIND_UNKNOWN_CMD;
                    end
                end
                char_count_next = '0;
                seen_next       = 1'b0;
                gap_next        = 1'b0;
                bad_next        = 1'b0;
                colon_next      = 1'b0;
                mstate_next     = M_START;
                mpos_next       = 3'd0;
            end else if (is_blank) begin
                // Whitespace only counts as a gap once content has started.
                char_count_next = char_count_reg + 1'b1;
                if (seen_reg) begin
                    gap_next = 1'b1;
                end
            end else begin
                char_count_next = char_count_reg + 1'b1;
                bad_next        = bad_now;
                seen_next       = 1'b1;
                gap_next        = 1'b0;
                // Advance the match automaton on a clean character.
                if (!bad_now) begin
                    if (!colon_reg) begin
                        if (step_byte == CHAR_COLON) begin
                            colon_next = 1'b1;
                            if (mstate_reg == M_CMD && mpos_reg == 3'd3) begin
                                mstate_next = M_CMD_PAY;
                                mpos_next   = 3'd0;
                            end else if (mstate_reg == M_STATUS && mpos_reg == 3'd6) begin
                                mstate_next = M_STATUS_PAY;
                            end else begin
                                mstate_next = M_OTHER_PAY;
                            end
                        end else begin
                            unique case (mstate_reg)
                                M_START: begin
                                    if (step_byte == "P") begin
                                        mstate_next = M_P;
                                    end else if (step_byte == "C") begin
                                        mstate_next = M_CMD;
                                        mpos_next   = 3'd1;
                                    end else if (step_byte == "S") begin
                                        mstate_next = M_STATUS;
                                        mpos_next   = 3'd1;
                                    end else begin
                                        mstate_next = M_TYPE_OTHER;
                                    end
                                end
                                M_P: begin
                                    if (step_byte == "I") begin
                                        mstate_next = M_PING;
                                        mpos_next   = 3'd2;
                                    end else if (step_byte == "O") begin
                                        mstate_next = M_PONG;
                                        mpos_next   = 3'd2;
                                    end else begin
                                        mstate_next = M_TYPE_OTHER;
                                    end
                                end
                                M_PING: begin
                                    if (mpos_reg < 3'd4 && ping_char(mpos_reg) == step_byte)
                                        mpos_next = mpos_reg + 1'b1;
                                    else
                                        mstate_next = M_TYPE_OTHER;
                                end
                                M_PONG: begin
                                    if (mpos_reg < 3'd4 && pong_char(mpos_reg) == step_byte)
                                        mpos_next = mpos_reg + 1'b1;
                                    else
                                        mstate_next = M_TYPE_OTHER;
                                end
                                M_CMD: begin
                                    if (mpos_reg < 3'd3 && cmd_char(mpos_reg) == step_byte)
                                        mpos_next = mpos_reg + 1'b1;
                                    else
                                        mstate_next = M_TYPE_OTHER;
                                end
                                M_STATUS: begin
                                    if (mpos_reg < 3'd6 && status_char(mpos_reg) == step_byte)
                                        mpos_next = mpos_reg + 1'b1;
                                    else
                                        mstate_next = M_TYPE_OTHER;
                                end
                                default: begin
                                    mstate_next = M_TYPE_OTHER;
                                end
                            endcase
                        end
                    end else begin
                        // Payload after the first colon.
                        unique case (mstate_reg)
                            M_CMD_PAY: begin
                                if (mpos_reg < 3'd5 && led_char(mpos_reg) == step_byte)
                                    mpos_next = mpos_reg + 1'b1;
                                else if (mpos_reg == 3'd5 && step_byte == "N")
                                    mstate_next = M_CMD_ON;
                                else if (mpos_reg == 3'd5 && step_byte == "F")
                                    mstate_next = M_CMD_OF;
                                else
                                    mstate_next = M_CMD_UNK;
                            end
                            M_CMD_OF: begin
                                mstate_next = (step_byte == "F") ? M_CMD_OFF : M_CMD_UNK;
                            end
                            M_CMD_ON, M_CMD_OFF: begin
                                mstate_next = M_CMD_UNK;
                            end
                            M_CMD_UNK, M_STATUS_PAY, M_OTHER_PAY: begin
                                mstate_next = mstate_reg;
                            end
                            default: begin
                                mstate_next = M_OTHER_PAY;
                            end
                        endcase
                    end
                end
            end
        end

        res_data.reply     = reply_sel;
        res_data.line_kind = kind_sel;
        res_data.led_on    = led_next;
    end

    // Line state and LED level.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            char_count_reg <= '0;
            seen_reg       <= 1'b0;
            gap_reg        <= 1'b0;
            bad_reg        <= 1'b0;
            colon_reg      <= 1'b0;
            mstate_reg     <= M_START;
            mpos_reg       <= 3'd0;
            led_reg        <= 1'b0;
        end else begin
            char_count_reg <= char_count_next;
            seen_reg       <= seen_next;
            gap_reg        <= gap_next;
            bad_reg        <= bad_next;
            colon_reg      <= colon_next;
            mstate_reg     <= mstate_next;
            mpos_reg       <= mpos_next;
            led_reg        <= led_next;
        end
    end

endmodule

>>> sv/lcp_out_reg.sv
// Result register of the line command parser: holds one result request
// until the downstream side takes it, and tells the core when it may step.
// Depends on lcp_pkg.
module lcp_out_reg (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             res_valid,
    input  lcp_pkg::result_t res_data,
    output logic             can_load,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [7:0]       m_tdata
);
    import lcp_pkg::*;

    logic    valid_reg, valid_next;
    result_t data_reg;

    // The slot is free when empty or when its request leaves this cycle.
    assign can_load   = !valid_reg || m_tready;
    assign valid_next = can_load ? res_valid : valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (can_load && res_valid) begin
            data_reg <= res_data;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;

endmodule

>>> tb/sv/tb_line_command_parser.sv
// Self-checking testbench for line_command_parser: streams text lines in byte by byte,
// predicts each line result and compares it with the result channel.
// Depends on lcp_pkg and the line_command_parser RTL.
module tb_line_command_parser;
    import lcp_pkg::*;

    localparam int IDLE_LIMIT   = 2000;
    localparam int DRAIN_CYCLES = 16;
    localparam int BYTE_TARGET  = 1300;

    // Receiver stall patterns.
    typedef enum int {
        SINK_ALWAYS,
        SINK_COIN,
        SINK_SPARSE,
        SINK_ALTERNATE
    } sink_mode_t;

    // One expected line result.
    typedef struct {
        reply_t reply;
        kind_t  kind;
        logic   led;
    } line_result_t;

    logic       aclk     = 1'b0;
    logic       aresetn  = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata  = 8'h00;   // rx_byte[7:0]
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;            // reply[2:0], line_kind[6:3], led_on[7]

    line_command_parser uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    logic [7:0]   rx_stream[$];         // bytes waiting to be offered
    logic [7:0]   line_bytes[$];        // line under construction
    line_result_t line_results_due[$];  // predicted results, oldest first
    int           bytes_planned = 0;
    int           mismatch_count = 0;
    int           results_checked = 0;
    int           kinds_seen[10];

    // Parser state as predicted from the accepted bytes.
    int     line_len = 0;
    bit     has_text = 1'b0;
    bit     blank_pending = 1'b0;
    bit     bad_chars = 1'b0;
    bit     colon_found = 1'b0;
    bit     led_state = 1'b0;
    match_t m_state = M_START;
    int     m_pos = 0;

    function automatic void restart_line();
        line_len      = 0;
        has_text      = 1'b0;
        blank_pending = 1'b0;
        bad_chars     = 1'b0;
        colon_found   = 1'b0;
        m_state       = M_START;
        m_pos         = 0;
    endfunction

    function automatic bit word_char_is(input string kw, input int pos, input logic [7:0] c);
        return pos < kw.len() && kw[pos] == c;
    endfunction

    // Matching of the line type, up to the first colon.
    function automatic void track_type(input logic [7:0] c);
        if (c == CHAR_COLON) begin
            colon_found = 1'b1;
            if (m_state == M_CMD && m_pos == 3) begin
                m_state = M_CMD_PAY;
                m_pos   = 0;
            end else if (m_state == M_STATUS && m_pos == 6) begin
                m_state = M_STATUS_PAY;
            end else begin
                m_state = M_OTHER_PAY;
            end
        end else begin
            case (m_state)
                M_START: begin
                    if (c == "P") begin
                        m_state = M_P;
                    end else if (c == "C") begin
                        m_state = M_CMD;
                        m_pos   = 1;
                    end else if (c == "S") begin
                        m_state = M_STATUS;
                        m_pos   = 1;
                    end else begin
                        m_state = M_TYPE_OTHER;
                    end
                end
                M_P: begin
                    if (c == "I") begin
                        m_state = M_PING;
                        m_pos   = 2;
                    end else if (c == "O") begin
                        m_state = M_PONG;
                        m_pos   = 2;
                    end else begin
                        m_state = M_TYPE_OTHER;
                    end
                end
                M_PING:   if (word_char_is("PING", m_pos, c)) m_pos++; else m_state = M_TYPE_OTHER;
                M_PONG:   if (word_char_is("PONG", m_pos, c)) m_pos++; else m_state = M_TYPE_OTHER;
                M_CMD:    if (word_char_is("CMD", m_pos, c)) m_pos++; else m_state = M_TYPE_OTHER;
                M_STATUS: if (word_char_is("STATUS", m_pos, c)) m_pos++; else m_state = M_TYPE_OTHER;
                default:  m_state = M_TYPE_OTHER;
            endcase
        end
    endfunction

    // Matching of the payload after the first colon; later colons are plain payload.
    function automatic void track_payload(input logic [7:0] c);
        case (m_state)
            M_CMD_PAY: begin
                if (word_char_is("LED_O", m_pos, c)) begin
                    m_pos++;
                end else if (m_pos == 5 && c == "N") begin
                    m_state = M_CMD_ON;
                end else if (m_pos == 5 && c == "F") begin
                    m_state = M_CMD_OF;
                end else begin
                    m_state = M_CMD_UNK;
                end
            end
            M_CMD_OF:                           m_state = (c == "F") ? M_CMD_OFF : M_CMD_UNK;
            M_CMD_ON, M_CMD_OFF:                m_state = M_CMD_UNK;
            M_CMD_UNK, M_STATUS_PAY, M_OTHER_PAY: ;
            default:                            m_state = M_OTHER_PAY;
        endcase
    endfunction

    // Advances the predicted parser by one accepted byte and queues any line result.
    function automatic void parse_rx_byte(input logic [7:0] c);
        line_result_t r;
        if (c == CHAR_CR) return;
        if (c == CHAR_LF) begin
            if (!has_text) begin
                restart_line();
                return;
            end
            if (bad_chars) begin
                r.reply = REPLY_ERROR;   r.kind = KIND_BAD_CHARSET;
            end else if (m_state == M_PING && m_pos == 4) begin
                r.reply = REPLY_PONG;    r.kind = KIND_PING;
            end else if (m_state == M_PONG && m_pos == 4) begin
                r.reply = REPLY_NONE;    r.kind = KIND_PONG;
            end else if (!colon_found) begin
                r.reply = REPLY_ERROR;   r.kind = KIND_NO_COLON;
            end else if (m_state == M_CMD_ON) begin
                led_state = 1'b1;
                r.reply = REPLY_OK;      r.kind = KIND_LED_ON;
            end else if (m_state == M_CMD_OFF) begin
                led_state = 1'b0;
                r.reply = REPLY_OK;      r.kind = KIND_LED_OFF;
            end else if (m_state == M_STATUS_PAY) begin
                r.reply = REPLY_NONE;    r.kind = KIND_STATUS;
            end else if (m_state == M_OTHER_PAY) begin
                r.reply = REPLY_ERROR;   r.kind = KIND_UNKNOWN_TYPE;
            end else begin
                r.reply = REPLY_UNKNOWN; r.kind = KIND_UNKNOWN_CMD;
            end
            r.led = led_state;
            line_results_due.push_back(r);
            restart_line();
            return;
        end
        // A byte beyond the length limit drops the whole line.
        if (line_len >= LCP_LINE_LIMIT) begin
            restart_line();
            r.reply = REPLY_ERROR;
            r.kind  = KIND_OVERFLOW;
            r.led   = led_state;
            line_results_due.push_back(r);
            return;
        end
        line_len++;
        if (c == 8'h09 || c == 8'h0B || c == 8'h0C || c == 8'h20) begin
            if (has_text) blank_pending = 1'b1;
            return;
        end
        if (blank_pending || !((c >= "A" && c <= "Z") || (c >= "0" && c <= "9")
                || c == "_" || c == CHAR_COLON))
            bad_chars = 1'b1;
        has_text      = 1'b1;
        blank_pending = 1'b0;
        if (!bad_chars) begin
            if (!colon_found) track_type(c);
            else track_payload(c);
        end
    endfunction

    // Line building helpers for the stimulus.
    function automatic logic [7:0] rand_allowed(input bit with_colon);
        string letters;
        letters = "ABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789_:";
        return letters[$urandom_range(0, letters.len() - (with_colon ? 1 : 2))];
    endfunction

    function automatic logic [7:0] rand_blank();
        case ($urandom_range(0, 3))
            0:       return 8'h09;
            1:       return 8'h0B;
            2:       return 8'h0C;
            default: return 8'h20;
        endcase
    endfunction

    function automatic logic [7:0] rand_junk();
        logic [7:0] b;
        do b = 8'($urandom_range(0, 255)); while (b == CHAR_LF || b == CHAR_CR);
        return b;
    endfunction

    task automatic add_byte(input logic [7:0] b);
        line_bytes.push_back(b);
    endtask

    task automatic add_word(input string w);
        for (int i = 0; i < w.len(); i++) line_bytes.push_back(w[i]);
    endtask

    task automatic add_ident(input int n, input bit with_colon);
        repeat (n) line_bytes.push_back(rand_allowed(with_colon));
    endtask

    task automatic push_rx(input logic [7:0] b);
        rx_stream.push_back(b);
        if (b != CHAR_CR) bytes_planned++;
    endtask

    // Moves the built line into the stream; decoration adds blanks and stray CRs.
    task automatic finish_line(input bit decorate);
        int lead;
        int trail;
        lead  = (decorate && $urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
        trail = (decorate && $urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
        repeat (lead) push_rx(rand_blank());
        foreach (line_bytes[i]) begin
            if (decorate && $urandom_range(0, 31) == 0) push_rx(CHAR_CR);
            push_rx(line_bytes[i]);
        end
        repeat (trail) push_rx(rand_blank());
        if (decorate && $urandom_range(0, 2) == 0) push_rx(CHAR_CR);
        push_rx(CHAR_LF);
        line_bytes.delete();
    endtask

    // One random line: mostly well-formed commands with random content, some noise.
    task automatic send_random_line();
        int    pick;
        int    cut;
        string kw;
        pick = $urandom_range(0, 99);
        if (pick < 10) begin
            add_word("PING");
        end else if (pick < 15) begin
            add_word("PONG");
        end else if (pick < 25) begin
            add_word("CMD:LED_ON");
        end else if (pick < 35) begin
            add_word("CMD:LED_OFF");
        end else if (pick < 45) begin
            // Near misses of the LED commands.
            kw  = "LED_OFF";
            cut = $urandom_range(0, 7);
            add_word("CMD:");
            for (int i = 0; i < cut; i++) add_byte(kw[i]);
            add_ident($urandom_range(0, 3), 1'b1);
        end else if (pick < 55) begin
            add_word("STATUS:");
            add_ident($urandom_range(0, 8), 1'b1);
        end else if (pick < 63) begin
            add_ident($urandom_range(1, 8), 1'b0);
        end else if (pick < 71) begin
            add_ident($urandom_range(1, 6), 1'b0);
            add_byte(CHAR_COLON);
            add_ident($urandom_range(0, 6), 1'b1);
        end else if (pick < 81) begin
            // Truncated or extended keywords.
            case (pick % 4)
                0:       kw = "PING";
                1:       kw = "PONG";
                2:       kw = "CMD";
                default: kw = "STATUS";
            endcase
            cut = $urandom_range(1, kw.len());
            for (int i = 0; i < cut; i++) add_byte(kw[i]);
            if ($urandom_range(0, 1) == 0) add_byte(rand_allowed(1'b0));
            if ($urandom_range(0, 1) == 0) begin
                add_byte(CHAR_COLON);
                add_ident($urandom_range(0, 4), 1'b1);
            end
        end else if (pick < 89) begin
            // A well-formed line with one byte replaced by arbitrary data.
            add_word("STATUS:");
            add_ident($urandom_range(1, 6), 1'b1);
            line_bytes[$urandom_range(0, line_bytes.size() - 1)] =
                ($urandom_range(0, 3) == 0) ? rand_blank() : rand_junk();
        end else if (pick < 93) begin
            repeat ($urandom_range(1, 12)) begin
                if ($urandom_range(0, 7) == 0) add_byte(CHAR_CR);
                else add_byte(rand_junk());
            end
        end else if (pick < 96) begin
            repeat ($urandom_range(0, 3)) add_byte(rand_blank());
        end else begin
            // Lengths around the line limit.
            add_word("CMD:");
            add_ident($urandom_range(56, 66), 1'b1);
        end
        finish_line(1'b1);
    endtask

    // Stimulus: directed lines, random lines, then reset release and end of run.
    initial begin
        add_word("PING");                    finish_line(1'b0);
        add_word("PONG");                    finish_line(1'b0);
        add_word("CMD:LED_ON");              finish_line(1'b0);
        add_word("CMD:LED_OFF");             finish_line(1'b0);
        add_word("CMD:LED_OFFF");            finish_line(1'b0);
        add_word("CMD:LED_");                finish_line(1'b0);
        add_word("CMD:LED_ON:X");            finish_line(1'b0);
        add_word("STATUS:OK");               finish_line(1'b0);
        add_word("STATUS:A:B");              finish_line(1'b0);
        add_word("STATUS");                  finish_line(1'b0);
        add_word("HELLO");                   finish_line(1'b0);
        add_word("FOO:BAR");                 finish_line(1'b0);
        add_word("PING:");                   finish_line(1'b0);
        add_word("CM:X");                    finish_line(1'b0);
        // Leading and trailing whitespace of every kind is trimmed.
        add_byte(8'h20); add_byte(8'h09); add_word("PING");
        add_byte(8'h0B); add_byte(8'h0C);    finish_line(1'b0);
        add_word("PI NG");                   finish_line(1'b0);
        add_word("ping");                    finish_line(1'b0);
        add_word("PI"); add_byte(8'h00); add_byte(8'hFF); add_word("NG");
        finish_line(1'b0);
        // Empty and blank-only lines give nothing; CRs within a line are ignored.
        finish_line(1'b0);
        add_byte(8'h20); add_byte(8'h09);    finish_line(1'b0);
        add_byte("P"); add_byte(CHAR_CR); add_word("ING"); add_byte(CHAR_CR);
        finish_line(1'b0);
        // Exactly at the limit, one byte over, and blanks alone over the limit.
        add_word("CMD:"); add_ident(LCP_LINE_LIMIT - 4, 1'b1);  finish_line(1'b0);
        add_word("CMD:"); add_ident(LCP_LINE_LIMIT - 3, 1'b1);  finish_line(1'b0);
        repeat (LCP_LINE_LIMIT + 1) add_byte(8'h20);            finish_line(1'b0);

        while (bytes_planned < BYTE_TARGET) send_random_line();

        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        while (rx_stream.size() != 0 || s_tvalid || line_results_due.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        // A result still waiting here was never predicted.
        if (m_tvalid) begin
            mismatch_count++;
            $display("%0t: line result left over: expected none, actual reply %0d kind %0d led %0d",
                     $time, m_tdata[2:0], m_tdata[6:3], m_tdata[7]);
        end

        $display("Run summary: %0d bytes sent, %0d line results checked.",
                 bytes_planned, results_checked);
        $display("  ping %0d, pong %0d, LED on/off %0d/%0d, unknown command %0d, status %0d,",
                 kinds_seen[KIND_PING], kinds_seen[KIND_PONG], kinds_seen[KIND_LED_ON],
                 kinds_seen[KIND_LED_OFF], kinds_seen[KIND_UNKNOWN_CMD], kinds_seen[KIND_STATUS]);
        $display("  no colon %0d, unknown type %0d, bad charset %0d, overflow %0d.",
                 kinds_seen[KIND_NO_COLON], kinds_seen[KIND_UNKNOWN_TYPE],
                 kinds_seen[KIND_BAD_CHARSET], kinds_seen[KIND_OVERFLOW]);
        if (mismatch_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    // Byte driver: bursts of requests with random gaps, fed from the stream queue.
    bit byte_taken = 1'b0;
    int burst_left = 8;
    int gap_left   = 0;

    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || byte_taken) begin
            if (gap_left != 0) begin
                gap_left--;
                s_tvalid <= 1'b0;
            end else if (rx_stream.size() != 0) begin
                s_tdata  <= rx_stream.pop_front();
                s_tvalid <= 1'b1;
                if (burst_left <= 1) begin
                    burst_left = $urandom_range(1, 24);
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                end else begin
                    burst_left--;
                end
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Result receiver: changing stall patterns plus occasional long hold-offs.
    sink_mode_t sink_mode = SINK_ALWAYS;
    int         mode_left = 24;
    int         hold_left = 0;
    bit         long_hold_done = 1'b0;
    bit         ready_toggle = 1'b0;

    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (hold_left != 0) begin
                hold_left--;
            end else if (mode_left == 0) begin
                mode_left = $urandom_range(16, 64);
                sink_mode = sink_mode_t'($urandom_range(0, 3));
                if (!long_hold_done || $urandom_range(0, 15) == 0) begin
                    long_hold_done = 1'b1;
                    hold_left      = $urandom_range(60, 90);
                end
            end else begin
                mode_left--;
            end
            if (hold_left != 0) begin
                m_tready <= 1'b0;
            end else begin
                case (sink_mode)
                    SINK_ALWAYS: m_tready <= 1'b1;
                    SINK_COIN:   m_tready <= ($urandom_range(0, 1) == 1);
                    SINK_SPARSE: m_tready <= ($urandom_range(0, 3) == 0);
                    default: begin
                        ready_toggle = !ready_toggle;
                        m_tready <= ready_toggle;
                    end
                endcase
            end
        end
    end

    // Prediction on accepted bytes and checking of accepted line results.
    always @(posedge aclk) begin
        line_result_t exp;
        byte_taken <= aresetn && s_tvalid && s_tready;
        if (aresetn && m_tvalid && m_tready) begin
            if (line_results_due.size() == 0) begin
                mismatch_count++;
                $display("%0t: line result with none expected: reply %0d kind %0d led %0d",
                         $time, m_tdata[2:0], m_tdata[6:3], m_tdata[7]);
            end else begin
                exp = line_results_due.pop_front();
                results_checked++;
                kinds_seen[exp.kind]++;
                if (m_tdata[2:0] !== exp.reply) begin
                    mismatch_count++;
                    $display("%0t: reply mismatch: expected %0d, actual %0d",
                             $time, exp.reply, m_tdata[2:0]);
                end
                if (m_tdata[6:3] !== exp.kind) begin
                    mismatch_count++;
                    $display("%0t: line kind mismatch: expected %0d, actual %0d",
                             $time, exp.kind, m_tdata[6:3]);
                end
                if (m_tdata[7] !== exp.led) begin
                    mismatch_count++;
                    $display("%0t: LED level mismatch: expected %0d, actual %0d",
                             $time, exp.led, m_tdata[7]);
                end
            end
        end
        if (aresetn && s_tvalid && s_tready) parse_rx_byte(s_tdata);
    end

    // Watchdog: too long without any request moving on either side ends the run.
    int idle_cycles = 0;

    always @(posedge aclk) begin
        if (aresetn && !((s_tvalid && s_tready) || (m_tvalid && m_tready))) begin
            idle_cycles <= idle_cycles + 1;
        end else begin
            idle_cycles <= 0;
        end
        if (idle_cycles == IDLE_LIMIT) begin
            $display("%0t: no progress for %0d cycles, %0d results outstanding",
                     $time, IDLE_LIMIT, line_results_due.size());
            $display("FAILURE");
            $finish;
        end
    end

endmodule
